// ===== rtl/core/jmse_pkg.sv =====
package jmse_pkg;

  typedef enum logic [1:0] {
    MODE_OUT   = 2'd0,
    MODE_IN    = 2'd1,
    MODE_AFTER = 2'd2
  } scan_mode_t;

  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_MATH = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } result_t;

  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // literal candidates, one bit each
  localparam int LIT_COUNT   = 5;
  localparam int HIT_T       = 0;
  localparam int HIT_C       = 1;
  localparam int HIT_MATH    = 2;
  localparam int HIT_DISPLAY = 3;
  localparam int HIT_INLINE  = 4;

  localparam logic [2:0] STAGE_KEY_T    = 3'd0;
  localparam logic [2:0] STAGE_MATH     = 3'd1;
  localparam logic [2:0] STAGE_KEY_C    = 3'd2;
  localparam logic [2:0] STAGE_KEY_T2   = 3'd3;
  localparam logic [2:0] STAGE_FLAVOR   = 3'd4;
  localparam logic [2:0] STAGE_CONTENT  = 3'd5;

  localparam logic [3:0] POS_MAX = 4'd15;

  typedef logic [7:0] lit_row_t [16];

  localparam lit_row_t LIT_TEXT [LIT_COUNT] = '{
    '{"t", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
      8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"c", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
      8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"M", "a", "t", "h", 8'h0, 8'h0, 8'h0, 8'h0,
      8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"D", "i", "s", "p", "l", "a", "y", "M",
      "a", "t", "h", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"I", "n", "l", "i", "n", "e", "M", "a",
      "t", "h", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0}
  };

  localparam logic [3:0] LIT_LEN [LIT_COUNT] = '{4'd1, 4'd1, 4'd4, 4'd11, 4'd10};

endpackage

// ===== rtl/core/json_math_string_extractor_unit.sv =====
// Scans a compact JSON document one byte per beat and passes every byte
// through (out_kind 0), except the content string of a math element found by
// the pattern key "t", "Math", key "c", key "t", "DisplayMath"/"InlineMath",
// content string. That string's quotes are dropped, its body comes out
// unescaped (out_kind 1, backslash-n becomes newline) and a zero byte with
// out_kind 2 marks its end. A byte gives at most one result beat. Throughput
// is one byte per cycle: all per-byte state updates happen as the byte is taken
// and the result lands in a single output register, so a byte is taken whenever
// that register is empty or draining. A byte's result shows the cycle after.
module json_math_string_extractor_unit import jmse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    full_stalled;

  assign in_stall = full_stalled;
  assign accept   = in_valid && !full_stalled;

  jmse_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  jmse_out_reg u_out_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (accept && res_valid),
    .load_res     (res),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_res      (out_res),
    .full_stalled (full_stalled)
  );

  assign out_byte = out_res.data;
  assign out_kind = out_res.kind;

endmodule

// ===== rtl/core/jmse_scan.sv =====
module jmse_scan import jmse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  output logic       res_valid,
  output result_t    res
);

  scan_mode_t             mode_r, mode_nxt;
  logic [2:0]             stage_r, stage_nxt;
  logic [3:0]             pos_r, pos_nxt;
  logic [LIT_COUNT-1:0]   hits_r, hits_nxt;
  logic                   math_r, math_nxt;
  logic                   esc_r, esc_nxt;

  logic [LIT_COUNT-1:0]   match_hits;
  logic [LIT_COUNT-1:0]   close_hits;
  logic [2:0]             stage_v;

  function automatic logic [2:0] judge(input logic [2:0] stage,
                                       input logic [LIT_COUNT-1:0] hits,
                                       input logic colon);
    logic [2:0] nxt;
    nxt = STAGE_KEY_T;
    unique case (stage)
      STAGE_KEY_T:  if (hits[HIT_T] && colon) nxt = STAGE_MATH;
      STAGE_KEY_T2: if (hits[HIT_T] && colon) nxt = STAGE_FLAVOR;
      STAGE_MATH:   if (hits[HIT_MATH]) nxt = STAGE_KEY_C;
      STAGE_KEY_C:  if (hits[HIT_C] && colon) nxt = STAGE_KEY_T2;
      STAGE_FLAVOR: if (hits[HIT_DISPLAY] || hits[HIT_INLINE]) nxt = STAGE_CONTENT;
      default:      nxt = STAGE_KEY_T;
    endcase
    return nxt;
  endfunction

  always_comb begin
    for (int k = 0; k < LIT_COUNT; k++) begin
      match_hits[k] = hits_r[k] && (pos_r < LIT_LEN[k]) &&
                      (LIT_TEXT[k][pos_r] == in_byte);
      close_hits[k] = hits_r[k] && (pos_r == LIT_LEN[k]);
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    stage_nxt = stage_r;
    pos_nxt   = pos_r;
    hits_nxt  = hits_r;
    math_nxt  = math_r;
    esc_nxt   = esc_r;
    res_valid = 1'b0;
    res.data  = in_byte;
    res.kind  = KIND_PASS;
    stage_v   = stage_r;

    unique case (mode_r)
      MODE_IN: begin
        if (math_r) begin
          if (esc_r) begin
            esc_nxt   = 1'b0;
            res_valid = 1'b1;
            res.kind  = KIND_MATH;
            res.data  = (in_byte == CH_N) ? CH_NEWLINE : in_byte;
          end else if (in_byte == CH_BSLASH) begin
            esc_nxt = 1'b1;
          end else if (in_byte == CH_QUOTE) begin
            math_nxt  = 1'b0;
            mode_nxt  = MODE_OUT;
            stage_nxt = STAGE_KEY_T;
            res_valid = 1'b1;
            res.kind  = KIND_END;
            res.data  = 8'h00;
          end else begin
            res_valid = 1'b1;
            res.kind  = KIND_MATH;
          end
        end else begin
          res_valid = 1'b1;
          if (esc_r) begin
            esc_nxt  = 1'b0;
            hits_nxt = '0;
          end else if (in_byte == CH_BSLASH) begin
            esc_nxt  = 1'b1;
            hits_nxt = '0;
          end else if (in_byte == CH_QUOTE) begin
            hits_nxt = close_hits;
            mode_nxt = MODE_AFTER;
          end else begin
            hits_nxt = match_hits;
            if (pos_r != POS_MAX) pos_nxt = pos_r + 4'd1;
          end
        end
      end
      default: begin
        // byte after a closing quote first judges that string against the pattern (a colon marks a key)
        if (mode_r == MODE_AFTER) stage_v = judge(stage_r, hits_r, in_byte == CH_COLON);
        stage_nxt = stage_v;
        mode_nxt  = MODE_OUT;
        res_valid = 1'b1;
        if (in_byte == CH_QUOTE) begin
          mode_nxt = MODE_IN;
          esc_nxt  = 1'b0;
          pos_nxt  = '0;
          hits_nxt = '1;
          if (stage_v == STAGE_CONTENT) begin
            math_nxt  = 1'b1;
            res_valid = 1'b0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_OUT;
      stage_r <= STAGE_KEY_T;
      pos_r   <= '0;
      hits_r  <= '0;
      math_r  <= 1'b0;
      esc_r   <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      stage_r <= stage_nxt;
      pos_r   <= pos_nxt;
      hits_r  <= hits_nxt;
      math_r  <= math_nxt;
      esc_r   <= esc_nxt;
    end
  end

endmodule

// ===== rtl/core/jmse_out_reg.sv =====
module jmse_out_reg import jmse_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_res,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t out_res,
  output logic    full_stalled
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // a new beat may land while the held one drains in the same cycle
  assign full_stalled = valid_r && out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (valid_r && !out_stall) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== tb/json_math_string_extractor_unit_test.sv =====
`timescale 1ns / 1ps

module json_math_string_extractor_unit_test import jmse_pkg::*;;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;

  json_math_string_extractor_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .out_kind(out_kind)
  );

  always #5 clk = ~clk;

  result_t    predicted_beats[$];
  logic [7:0] chunk[$];
  int         fail_count = 0;
  int         items_sent = 0;
  int         stall_left = 0;
  bit         steady = 1'b0;

  // scanner state mirror
  scan_mode_t sc_mode = MODE_OUT;
  logic [2:0] sc_stage = STAGE_KEY_T;
  logic [3:0] body_len = '0;
  logic [4:0] lit_alive = '0;
  bit         in_content = 1'b0;
  bit         esc_seen = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_beat(input logic [7:0] d, input kind_t k);
    result_t r;
    r.data = d;
    r.kind = k;
    predicted_beats.push_back(r);
  endfunction

  function automatic void judge_string(input bit colon);
    logic [2:0] nxt;
    nxt = STAGE_KEY_T;
    case (sc_stage)
      STAGE_KEY_T, STAGE_KEY_T2: begin
        if (lit_alive[HIT_T] && colon) nxt = sc_stage + 3'd1;
      end
      STAGE_MATH: begin
        if (lit_alive[HIT_MATH]) nxt = STAGE_KEY_C;
      end
      STAGE_KEY_C: begin
        if (lit_alive[HIT_C] && colon) nxt = STAGE_KEY_T2;
      end
      STAGE_FLAVOR: begin
        if (lit_alive[HIT_DISPLAY] || lit_alive[HIT_INLINE]) nxt = STAGE_CONTENT;
      end
      default: nxt = STAGE_KEY_T;
    endcase
    sc_stage = nxt;
  endfunction

  // Advance the mirror by one accepted byte and queue the beat it yields.
  function automatic void scan_byte(input logic [7:0] b);
    logic [4:0] keep;
    keep = '0;
    if (sc_mode == MODE_IN) begin
      if (in_content) begin
        if (esc_seen) begin
          esc_seen = 1'b0;
          push_beat((b == CH_N) ? CH_NEWLINE : b, KIND_MATH);
        end else if (b == CH_BSLASH) begin
          esc_seen = 1'b1;
        end else if (b == CH_QUOTE) begin
          in_content = 1'b0;
          sc_mode = MODE_OUT;
          sc_stage = STAGE_KEY_T;
          push_beat(8'h00, KIND_END);
        end else begin
          push_beat(b, KIND_MATH);
        end
      end else begin
        if (esc_seen) begin
          esc_seen = 1'b0;
          lit_alive = '0;
        end else if (b == CH_BSLASH) begin
          esc_seen = 1'b1;
          lit_alive = '0;
        end else if (b == CH_QUOTE) begin
          for (int k = 0; k < LIT_COUNT; k++)
            keep[k] = lit_alive[k] && (body_len == LIT_LEN[k]);
          lit_alive = keep;
          sc_mode = MODE_AFTER;
        end else begin
          for (int k = 0; k < LIT_COUNT; k++)
            keep[k] = lit_alive[k] && (body_len < LIT_LEN[k]) &&
                      (LIT_TEXT[k][body_len] == b);
          lit_alive = keep;
          if (body_len != POS_MAX) body_len = body_len + 4'd1;
        end
        push_beat(b, KIND_PASS);
      end
    end else begin
      // byte after a closing quote judges that string against the pattern, then is scanned normally
      if (sc_mode == MODE_AFTER) judge_string(b == CH_COLON);
      sc_mode = MODE_OUT;
      if (b == CH_QUOTE) begin
        sc_mode = MODE_IN;
        esc_seen = 1'b0;
        body_len = '0;
        lit_alive = '1;
        if (sc_stage == STAGE_CONTENT) in_content = 1'b1;
        else push_beat(b, KIND_PASS);
      end else begin
        push_beat(b, KIND_PASS);
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_byte(b);
    items_sent++;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_chunk();
    while (chunk.size() != 0) send_byte(chunk.pop_front());
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) chunk.push_back(s[i]);
  endtask

  // random string body; escapes lean toward n, quote and backslash
  task automatic add_body(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) < 2) begin
        chunk.push_back(CH_BSLASH);
        case ($urandom_range(0, 3))
          0: b = CH_N;
          1: b = CH_QUOTE;
          2: b = CH_BSLASH;
          default: b = 8'($urandom_range(0, 255));
        endcase
      end else begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_QUOTE || b == CH_BSLASH) b = b ^ 8'h80;
      end
      chunk.push_back(b);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (predicted_beats.size() != 0) @(posedge clk);
  endtask

  // close any string left open by noise so the next element starts clean
  task automatic resync();
    while (sc_mode == MODE_IN) send_byte(esc_seen ? 8'h20 : CH_QUOTE);
  endtask

  task automatic test_passthrough_extremes();
    steady = 1'b0;
    chunk.push_back(8'h00);
    chunk.push_back(8'hFF);
    chunk.push_back(8'h55);
    chunk.push_back(8'hAA);
    add_text("\"a\\\"b\"\"t\"");
    send_chunk();
    resync();
  endtask

  task automatic test_math_escapes();
    steady = 1'b1;
    add_text("\"t\":\"Math\"\"c\":\"t\":\"InlineMath\"\"\\n\\\"a\":");
    send_chunk();
    steady = 1'b0;
    wait_drained();
  endtask

  task automatic add_math_element();
    int idx;
    add_text("{\"t\":\"Math\",\"c\":[{\"t\":\"");
    if ($urandom_range(0, 1)) add_text("DisplayMath");
    else add_text("InlineMath");
    add_text("\"},\"");
    add_body(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10));
    if ($urandom_range(0, 5) == 0) add_text("\":]}");
    else add_text("\"]}");
    // broken sequences: one byte replaced or dropped
    if ($urandom_range(0, 3) == 0) begin
      idx = $urandom_range(0, chunk.size() - 1);
      if ($urandom_range(0, 1)) chunk[idx] = 8'($urandom_range(0, 255));
      else chunk.delete(idx);
    end
  endtask

  task automatic add_random_string();
    chunk.push_back(CH_QUOTE);
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 4))
        0: add_text("t");
        1: add_text("c");
        2: add_text("Math");
        3: add_text("DisplayMath");
        default: add_text("InlineMath");
      endcase
    end else begin
      add_body($urandom_range(0, 20));
    end
    chunk.push_back(CH_QUOTE);
    if ($urandom_range(0, 1)) chunk.push_back(CH_COLON);
  endtask

  task automatic test_random_documents();
    int base;
    int r;
    int next_drain;
    base = items_sent;
    next_drain = base + 300;
    while (items_sent - base < 950) begin
      steady = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      resync();
      if (r < 60) add_math_element();
      else if (r < 85) add_random_string();
      else repeat ($urandom_range(1, 6)) chunk.push_back(8'($urandom_range(0, 255)));
      send_chunk();
      if (items_sent >= next_drain) begin
        wait_drained();
        next_drain = items_sent + 300;
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (steady || $urandom_range(0, 99) < 65) begin
      out_stall <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_stall <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_beats
    result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (predicted_beats.size() == 0) begin
        $display("%0t: unexpected beat, got byte %h kind %0d", $time, out_byte, out_kind);
        fail_count++;
      end else begin
        want = predicted_beats.pop_front();
        if (out_byte !== want.data) begin
          $display("%0t: out_byte expected %h, got %h", $time, want.data, out_byte);
          fail_count++;
        end
        if (out_kind !== want.kind) begin
          $display("%0t: out_kind expected %0d, got %0d", $time, want.kind, out_kind);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_passthrough_extremes();
    test_math_escapes();
    test_random_documents();
    while (predicted_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (predicted_beats.size() != 0) begin
      $display("%0t: %0d beats never arrived", $time, predicted_beats.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
